@@ rtl/dsv_pkg.sv @@
// Shared constants and types of the DSA signing and verification block.
`default_nettype none
package dsv_pkg;
   localparam int DSV_WIDTH = 32;

   // Operation codes of the shared arithmetic unit.
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_VALID   = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NOINV   = 2'd2;

   // Register reset values.
   localparam logic [31:0] RST_P = 32'd23;
   localparam logic [31:0] RST_Q = 32'd11;
   localparam logic [31:0] RST_G = 32'd4;
   localparam logic [31:0] RST_X = 32'd1;

   typedef struct packed {
      logic start;
      logic op;
   } au_ctl_type;
endpackage
`default_nettype wire

@@ rtl/dsv_arith.sv @@
// Bit-serial modular multiplier and restoring divider shared by the sequencer.
`default_nettype none
module dsv_arith #(
   parameter int W = dsv_pkg::DSV_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dsv_pkg::au_ctl_type   ctl,
   input  wire logic [W-1:0]          a,
   input  wire logic [W-1:0]          b,
   input  wire logic [W-1:0]          m,
   output logic                       done,
   output logic [W-1:0]               acc,
   output logic [W-1:0]               quo
);
   import dsv_pkg::*;

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          op_ff, op_in;
   logic          zero_ff, zero_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W:0]    shift_rem;

   // Modular add of two values already below the modulus.
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] lhs, input logic [W-1:0] rhs,
                                            input logic [W-1:0] md);
      logic [W-1:0] gap;
      gap = md - rhs;
      return (lhs >= gap) ? (lhs - gap) : (lhs + rhs);
   endfunction

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      zero_in   = zero_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      m_in      = m_ff;
      acc_in    = acc_ff;
      shift_rem = {acc_ff, x_ff[W-1]};
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         zero_in = (ctl.op == OP_MUL) ? (m == '0) : (b == '0);
         cnt_in  = '0;
         x_in    = a;
         y_in    = b;
         m_in    = m;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            if (y_ff[0]) begin
               acc_in = add_mod(acc_ff, x_ff, m_ff);
            end
            x_in = add_mod(x_ff, x_ff, m_ff);
            y_in = {1'b0, y_ff[W-1:1]};
         end else begin
            if (shift_rem >= {1'b0, y_ff}) begin
               acc_in = W'(shift_rem - {1'b0, y_ff});
               x_in   = {x_ff[W-2:0], 1'b1};
            end else begin
               acc_in = shift_rem[W-1:0];
               x_in   = {x_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      m_ff    <= m_in;
      acc_ff  <= acc_in;
   end

   // A zero modulus or divisor forces the acc output to zero; the quotient output is not masked.
   assign done = done_ff;
   assign acc  = zero_ff ? '0 : acc_ff;
   assign quo  = x_ff;
endmodule
`default_nettype wire

@@ rtl/dsa_sign_verify.sv @@
// Top level of the DSA signing and verification block: registers, sequencer and ports.
// Each transaction computes y = g^x mod p, the signature (r, s) for the given hash and
// nonce, and the verification value v, all on one shared arithmetic unit that retires a
// modular multiply or a division one bit per cycle. Four exponentiations of up to
// 2*WIDTH operations each and two extended Euclid inversions of up to about 1.5*WIDTH
// rounds dominate the work of an item. One item is worked on at a time; the next is
// taken as soon as the previous result has been handed to the output register.
`default_nettype none
module dsa_sign_verify #(
   parameter int WIDTH = dsv_pkg::DSV_WIDTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // message_hash [31:0], nonce_k [63:32]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // public_key, sig_r, sig_s, check_v, low first
   output logic [1:0]        rsp_tuser,   // status
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import dsv_pkg::*;

   localparam int W = WIDTH;

   localparam logic [1:0] REG_P = 2'd0;
   localparam logic [1:0] REG_Q = 2'd1;
   localparam logic [1:0] REG_G = 2'd2;
   localparam logic [1:0] REG_X = 2'd3;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_WAIT  = 5'd1;
   localparam logic [4:0] P_START = 5'd2;
   localparam logic [4:0] P_BASE  = 5'd3;
   localparam logic [4:0] P_LOOP  = 5'd4;
   localparam logic [4:0] P_ACC   = 5'd5;
   localparam logic [4:0] P_SQ    = 5'd6;
   localparam logic [4:0] P_SQD   = 5'd7;
   localparam logic [4:0] I_START = 5'd8;
   localparam logic [4:0] I_R1    = 5'd9;
   localparam logic [4:0] I_LOOP  = 5'd10;
   localparam logic [4:0] I_Q     = 5'd11;
   localparam logic [4:0] I_T     = 5'd12;
   localparam logic [4:0] S_Y1    = 5'd13;
   localparam logic [4:0] S_R1    = 5'd14;
   localparam logic [4:0] S_R2    = 5'd15;
   localparam logic [4:0] S_K1    = 5'd16;
   localparam logic [4:0] S_H1    = 5'd17;
   localparam logic [4:0] S_X1    = 5'd18;
   localparam logic [4:0] S_T1    = 5'd19;
   localparam logic [4:0] S_T2    = 5'd20;
   localparam logic [4:0] S_S1    = 5'd21;
   localparam logic [4:0] S_W1    = 5'd22;
   localparam logic [4:0] S_U1    = 5'd23;
   localparam logic [4:0] S_U2    = 5'd24;
   localparam logic [4:0] S_V1    = 5'd25;
   localparam logic [4:0] S_V2    = 5'd26;
   localparam logic [4:0] S_V3    = 5'd27;
   localparam logic [4:0] S_V4    = 5'd28;
   localparam logic [4:0] S_OUT   = 5'd29;

   logic [W-1:0] p_ff, p_in, q_ff, q_in, g_ff, g_in, x_ff, x_in;
   logic [W-1:0] h_ff, h_in, k_ff, k_in;
   logic [W-1:0] y_ff, y_in, r_ff, r_in, s_ff, s_in, v_ff, v_in;
   logic [W-1:0] kinv_ff, kinv_in, w_ff, w_in, hr_ff, hr_in, t_ff, t_in;
   logic [W-1:0] u1_ff, u1_in, u2_ff, u2_in, pa_ff, pa_in;
   logic [1:0]   status_ff, status_in;
   logic [4:0]   state_ff, state_in, ret_ff, ret_in;
   logic [4:0]   pw_ret_ff, pw_ret_in, iv_ret_ff, iv_ret_in;
   logic [W-1:0] pw_base_ff, pw_base_in, pw_exp_ff, pw_exp_in, pw_mod_ff, pw_mod_in;
   logic [W-1:0] pw_acc_ff, pw_acc_in;
   logic [W-1:0] iv_a_ff, iv_a_in, iv_r0_ff, iv_r0_in, iv_r1_ff, iv_r1_in;
   logic [W-1:0] iv_t0_ff, iv_t0_in, iv_t1_ff, iv_t1_in, iv_nr_ff, iv_nr_in;
   logic         iv_ok_ff, iv_ok_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_user_ff, rsp_user_in;

   au_ctl_type   au_ctl;
   logic [W-1:0] au_a, au_b, au_m, au_acc, au_quo, qm;
   logic         au_done;
   logic         cfg_wr;

   dsv_arith #(.W(W)) u_arith (
      .clock (clock),
      .reset (reset),
      .ctl   (au_ctl),
      .a     (au_a),
      .b     (au_b),
      .m     (au_m),
      .done  (au_done),
      .acc   (au_acc),
      .quo   (au_quo)
   );

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign qm         = (au_quo >= q_ff) ? (au_quo - q_ff) : au_quo;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_P:   csr_prdata = 32'(p_ff);
         REG_Q:   csr_prdata = 32'(q_ff);
         REG_G:   csr_prdata = 32'(g_ff);
         REG_X:   csr_prdata = 32'(x_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_comb begin
      p_in = p_ff; q_in = q_ff; g_in = g_ff; x_in = x_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[3:2])
            REG_P:   p_in = W'(csr_pwdata);
            REG_Q:   q_in = W'(csr_pwdata);
            REG_G:   g_in = W'(csr_pwdata);
            REG_X:   x_in = W'(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      h_in = h_ff; k_in = k_ff; y_in = y_ff; r_in = r_ff; s_in = s_ff; v_in = v_ff;
      kinv_in = kinv_ff; w_in = w_ff; hr_in = hr_ff; t_in = t_ff;
      u1_in = u1_ff; u2_in = u2_ff; pa_in = pa_ff; status_in = status_ff;
      state_in = state_ff; ret_in = ret_ff;
      pw_ret_in = pw_ret_ff; iv_ret_in = iv_ret_ff;
      pw_base_in = pw_base_ff; pw_exp_in = pw_exp_ff; pw_mod_in = pw_mod_ff;
      pw_acc_in = pw_acc_ff;
      iv_a_in = iv_a_ff; iv_r0_in = iv_r0_ff; iv_r1_in = iv_r1_ff;
      iv_t0_in = iv_t0_ff; iv_t1_in = iv_t1_ff; iv_nr_in = iv_nr_ff; iv_ok_in = iv_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      au_ctl = '{start: 1'b0, op: OP_MUL};
      au_a = '0; au_b = '0; au_m = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               h_in       = W'(req_tdata[31:0]);
               k_in       = W'(req_tdata[63:32]);
               pw_base_in = g_ff;
               pw_exp_in  = x_ff;
               pw_mod_in  = p_ff;
               pw_ret_in  = S_Y1;
               state_in   = P_START;
            end
         end
         S_WAIT: begin
            if (au_done) begin
               state_in = ret_ff;
            end
         end
         // Square-and-multiply exponentiation, lowest exponent bit first.
         P_START: begin
            if (pw_mod_ff == '0) begin
               pw_acc_in = '0;
               state_in  = pw_ret_ff;
            end else begin
               pw_acc_in = (pw_mod_ff == W'(1)) ? '0 : W'(1);
               au_ctl    = '{start: 1'b1, op: OP_DIV};
               au_a = pw_base_ff; au_b = pw_mod_ff;
               ret_in   = P_BASE;
               state_in = S_WAIT;
            end
         end
         P_BASE: begin
            pw_base_in = au_acc;
            state_in   = P_LOOP;
         end
         P_LOOP: begin
            if (pw_exp_ff == '0) begin
               state_in = pw_ret_ff;
            end else if (pw_exp_ff[0]) begin
               au_ctl = '{start: 1'b1, op: OP_MUL};
               au_a = pw_acc_ff; au_b = pw_base_ff; au_m = pw_mod_ff;
               ret_in   = P_ACC;
               state_in = S_WAIT;
            end else begin
               state_in = P_SQ;
            end
         end
         P_ACC: begin
            pw_acc_in = au_acc;
            state_in  = P_SQ;
         end
         P_SQ: begin
            au_ctl = '{start: 1'b1, op: OP_MUL};
            au_a = pw_base_ff; au_b = pw_base_ff; au_m = pw_mod_ff;
            ret_in   = P_SQD;
            state_in = S_WAIT;
         end
         P_SQD: begin
            pw_base_in = au_acc;
            pw_exp_in  = {1'b0, pw_exp_ff[W-1:1]};
            state_in   = P_LOOP;
         end
         // Extended Euclid inversion modulo q.
         I_START: begin
            if (q_ff < W'(2)) begin
               iv_ok_in = 1'b0;
               state_in = iv_ret_ff;
            end else begin
               iv_r0_in = q_ff;
               iv_t0_in = '0;
               iv_t1_in = W'(1);
               au_ctl   = '{start: 1'b1, op: OP_DIV};
               au_a = iv_a_ff; au_b = q_ff;
               ret_in   = I_R1;
               state_in = S_WAIT;
            end
         end
         I_R1: begin
            iv_r1_in = au_acc;
            state_in = I_LOOP;
         end
         I_LOOP: begin
            if (iv_r1_ff == '0) begin
               iv_ok_in = (iv_r0_ff == W'(1));
               state_in = iv_ret_ff;
            end else begin
               au_ctl = '{start: 1'b1, op: OP_DIV};
               au_a = iv_r0_ff; au_b = iv_r1_ff;
               ret_in   = I_Q;
               state_in = S_WAIT;
            end
         end
         I_Q: begin
            iv_nr_in = au_acc;
            au_ctl   = '{start: 1'b1, op: OP_MUL};
            au_a = qm; au_b = iv_t1_ff; au_m = q_ff;
            ret_in   = I_T;
            state_in = S_WAIT;
         end
         I_T: begin
            iv_t1_in = (iv_t0_ff >= au_acc) ? (iv_t0_ff - au_acc)
                                            : (iv_t0_ff + (q_ff - au_acc));
            iv_t0_in = iv_t1_ff;
            iv_r0_in = iv_r1_ff;
            iv_r1_in = iv_nr_ff;
            state_in = I_LOOP;
         end
         S_Y1: begin
            y_in       = pw_acc_ff;
            pw_base_in = g_ff;
            pw_exp_in  = k_ff;
            pw_mod_in  = p_ff;
            pw_ret_in  = S_R1;
            state_in   = P_START;
         end
         S_R1: begin
            au_ctl = '{start: 1'b1, op: OP_DIV};
            au_a = pw_acc_ff; au_b = q_ff;
            ret_in   = S_R2;
            state_in = S_WAIT;
         end
         S_R2: begin
            r_in      = au_acc;
            iv_a_in   = k_ff;
            iv_ret_in = S_K1;
            state_in  = I_START;
         end
         S_K1: begin
            if (!iv_ok_ff) begin
               s_in = '0; v_in = '0;
               status_in = ST_NOINV;
               state_in  = S_OUT;
            end else begin
               kinv_in = iv_t0_ff;
               au_ctl  = '{start: 1'b1, op: OP_DIV};
               au_a = h_ff; au_b = q_ff;
               ret_in   = S_H1;
               state_in = S_WAIT;
            end
         end
         S_H1: begin
            hr_in  = au_acc;
            au_ctl = '{start: 1'b1, op: OP_DIV};
            au_a = x_ff; au_b = q_ff;
            ret_in   = S_X1;
            state_in = S_WAIT;
         end
         S_X1: begin
            au_ctl = '{start: 1'b1, op: OP_MUL};
            au_a = au_acc; au_b = r_ff; au_m = q_ff;
            ret_in   = S_T1;
            state_in = S_WAIT;
         end
         S_T1: begin
            t_in = (hr_ff >= (q_ff - au_acc)) ? (hr_ff - (q_ff - au_acc)) : (hr_ff + au_acc);
            state_in = S_T2;
         end
         S_T2: begin
            au_ctl = '{start: 1'b1, op: OP_MUL};
            au_a = kinv_ff; au_b = t_ff; au_m = q_ff;
            ret_in   = S_S1;
            state_in = S_WAIT;
         end
         S_S1: begin
            s_in      = au_acc;
            iv_a_in   = au_acc;
            iv_ret_in = S_W1;
            state_in  = I_START;
         end
         S_W1: begin
            if (!iv_ok_ff) begin
               v_in = '0;
               status_in = ST_INVALID;
               state_in  = S_OUT;
            end else begin
               w_in   = iv_t0_ff;
               au_ctl = '{start: 1'b1, op: OP_MUL};
               au_a = hr_ff; au_b = iv_t0_ff; au_m = q_ff;
               ret_in   = S_U1;
               state_in = S_WAIT;
            end
         end
         S_U1: begin
            u1_in  = au_acc;
            au_ctl = '{start: 1'b1, op: OP_MUL};
            au_a = r_ff; au_b = w_ff; au_m = q_ff;
            ret_in   = S_U2;
            state_in = S_WAIT;
         end
         S_U2: begin
            u2_in      = au_acc;
            pw_base_in = g_ff;
            pw_exp_in  = u1_ff;
            pw_mod_in  = p_ff;
            pw_ret_in  = S_V1;
            state_in   = P_START;
         end
         S_V1: begin
            pa_in      = pw_acc_ff;
            pw_base_in = y_ff;
            pw_exp_in  = u2_ff;
            pw_mod_in  = p_ff;
            pw_ret_in  = S_V2;
            state_in   = P_START;
         end
         S_V2: begin
            au_ctl = '{start: 1'b1, op: OP_MUL};
            au_a = pa_ff; au_b = pw_acc_ff; au_m = p_ff;
            ret_in   = S_V3;
            state_in = S_WAIT;
         end
         S_V3: begin
            au_ctl = '{start: 1'b1, op: OP_DIV};
            au_a = au_acc; au_b = q_ff;
            ret_in   = S_V4;
            state_in = S_WAIT;
         end
         S_V4: begin
            v_in      = au_acc;
            status_in = (au_acc == r_ff) ? ST_VALID : ST_INVALID;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {32'(v_ff), 32'(s_ff), 32'(r_ff), 32'(y_ff)};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff         <= W'(RST_P);
         q_ff         <= W'(RST_Q);
         g_ff         <= W'(RST_G);
         x_ff         <= W'(RST_X);
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_ff         <= p_in;
         q_ff         <= q_in;
         g_ff         <= g_in;
         x_ff         <= x_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      h_ff <= h_in; k_ff <= k_in; y_ff <= y_in; r_ff <= r_in; s_ff <= s_in; v_ff <= v_in;
      kinv_ff <= kinv_in; w_ff <= w_in; hr_ff <= hr_in; t_ff <= t_in;
      u1_ff <= u1_in; u2_ff <= u2_in; pa_ff <= pa_in; status_ff <= status_in;
      ret_ff <= ret_in; pw_ret_ff <= pw_ret_in; iv_ret_ff <= iv_ret_in;
      pw_base_ff <= pw_base_in; pw_exp_ff <= pw_exp_in; pw_mod_ff <= pw_mod_in;
      pw_acc_ff <= pw_acc_in;
      iv_a_ff <= iv_a_in; iv_r0_ff <= iv_r0_in; iv_r1_ff <= iv_r1_in;
      iv_t0_ff <= iv_t0_in; iv_t1_ff <= iv_t1_in; iv_nr_ff <= iv_nr_in; iv_ok_ff <= iv_ok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // An accepted transaction always starts the sequencer.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start the sequencer");

   // The arithmetic unit only finishes while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      au_done |-> (state_ff == S_WAIT))
      else $error("arithmetic result arrived outside the wait state");

   // A nonce without inverse gives zero for s and v.
   a_noinv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_NOINV)) |-> (rsp_tdata[127:64] == '0))
      else $error("non-invertible nonce produced non-zero s or v");
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench of the DSA signing and verification block.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dsv_pkg::*;

   // The hash occupies the low half so that the packed item matches req_tdata.
   typedef struct packed {
      logic [31:0] nonce;
      logic [31:0] hash;
   } sign_req_t;

   typedef struct packed {
      logic [31:0] pub_key;
      logic [31:0] r;
      logic [31:0] s;
      logic [31:0] v;
      logic [1:0]  status;
   } sign_rsp_t;

   localparam logic [3:0] ADDR_P = 4'd0;
   localparam logic [3:0] ADDR_Q = 4'd4;
   localparam logic [3:0] ADDR_G = 4'd8;
   localparam logic [3:0] ADDR_X = 4'd12;
   localparam int MAX_CYCLES = 10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;    // message_hash [31:0], nonce_k [63:32]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // public_key, sig_r, sig_s, check_v, low first
   logic [1:0] rsp_tuser;          // status
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   dsa_sign_verify u_dut (.*);

   logic [31:0] grp_p, grp_q, grp_g, key_x;
   sign_req_t pending_reqs[$];
   sign_rsp_t expected_sigs[$];
   int mismatches = 0;
   int cycles = 0;
   bit calm = 1'b0;      // no idling on either side while set
   bit hold_rsp = 1'b0;  // long stall of the receiver
   int hold_left = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [31:0] mod_red(logic [63:0] a, logic [31:0] m);
      return (m == 0) ? 32'd0 : 32'(a % m);
   endfunction

   function automatic logic [31:0] mod_mul(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] m);
      return mod_red(64'(a) * 64'(b), m);
   endfunction

   function automatic logic [31:0] mod_pow(logic [31:0] b, logic [31:0] e,
                                           logic [31:0] m);
      logic [31:0] acc;
      if (m == 0) return 32'd0;
      acc = mod_red(1, m);
      b = mod_red(b, m);
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, b, m);
         b = mod_mul(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Extended Euclid; returns 0 in ok when no inverse exists.
   function automatic logic [31:0] mod_inv(logic [31:0] a, logic [31:0] m,
                                           output bit ok);
      longint r0, r1, t0, t1, quo, tmp;
      ok = 1'b0;
      if (m < 2) return 32'd0;
      r0 = m;
      r1 = a % m;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         quo = r0 / r1;
         tmp = r0 - quo * r1; r0 = r1; r1 = tmp;
         tmp = t0 - quo * t1; t0 = t1; t1 = tmp;
      end
      if (r0 != 1) return 32'd0;
      ok = 1'b1;
      t0 = t0 % longint'(m);
      if (t0 < 0) t0 = t0 + m;
      return 32'(t0);
   endfunction

   function automatic sign_rsp_t sign_and_verify(sign_req_t rq);
      sign_rsp_t o;
      logic [31:0] kinv, w, t, u1, u2;
      bit ok;
      o = '0;
      o.pub_key = mod_pow(grp_g, key_x, grp_p);
      o.r = mod_red(mod_pow(grp_g, rq.nonce, grp_p), grp_q);
      kinv = mod_inv(rq.nonce, grp_q, ok);
      if (!ok) begin
         o.status = ST_NOINV;
      end else begin
         t = mod_red(64'(mod_red(rq.hash, grp_q)) + 64'(mod_mul(key_x, o.r, grp_q)), grp_q);
         o.s = mod_mul(kinv, t, grp_q);
         w = mod_inv(o.s, grp_q, ok);
         if (!ok) begin
            o.status = ST_INVALID;
         end else begin
            u1 = mod_mul(rq.hash, w, grp_q);
            u2 = mod_mul(o.r, w, grp_q);
            o.v = mod_red(mod_mul(mod_pow(grp_g, u1, grp_p),
                                  mod_pow(o.pub_key, u2, grp_p), grp_p), grp_q);
            o.status = (o.v == o.r) ? ST_VALID : ST_INVALID;
         end
      end
      return o;
   endfunction

   // Driver: the expectation is formed at the accepting edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_sigs.push_back(sign_and_verify(sign_req_t'(req_tdata)));
            void'(pending_reqs.pop_front());
         end
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_reqs[0];
         end else if (!(req_tvalid && !req_tready)) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) hold_left <= hold_left - 1;
         else if (hold_rsp) begin
            hold_left <= 50000;
            hold_rsp <= 1'b0;
         end
         rsp_tready <= (hold_left <= 1 && !hold_rsp) && (calm || $urandom_range(99) >= 10);
      end
   end

   // Monitor
   always @(posedge clock) begin
      sign_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                rsp_tdata[127:96], rsp_tuser};
         if (expected_sigs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", got);
         end else begin
            want = expected_sigs.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: y %h/%h r %h/%h s %h/%h v %h/%h st %0d/%0d",
                           want.pub_key, got.pub_key, want.r, got.r, want.s, got.s,
                           want.v, got.v, want.status, got.status);
            end
         end
      end
   end

   task automatic csr_write(logic [3:0] addr, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (addr)
         ADDR_P: grp_p = val;
         ADDR_Q: grp_q = val;
         ADDR_G: grp_g = val;
         default: key_x = val;
      endcase
   endtask

   task automatic set_group(logic [31:0] p, logic [31:0] q, logic [31:0] g,
                            logic [31:0] x);
      csr_write(ADDR_P, p);
      csr_write(ADDR_Q, q);
      csr_write(ADDR_G, g);
      csr_write(ADDR_X, x);
   endtask

   task automatic run_and_drain();
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_sigs.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic add_item(logic [31:0] h, logic [31:0] k);
      pending_reqs.push_back('{hash: h, nonce: k});
   endtask

   initial begin
      grp_p = RST_P; grp_q = RST_Q; grp_g = RST_G; key_x = RST_X;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Reset group: extremes of the fields and a nonce that is a multiple of q.
      add_item(0, 0);
      add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(5, 3);
      add_item(7, 11);
      add_item(32'hAAAA_5555, 32'h5555_AAAA);
      add_item(1, 1);
      run_and_drain();
      // Modulus one and zero modulus.
      set_group(1, 1, 0, 0);
      add_item(3, 4);
      run_and_drain();
      set_group(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(3, 4);
      run_and_drain();
      // Composite q, so that s may fail to invert.
      set_group(13, 12, 2, 5);
      for (int i = 0; i < 8; i++) add_item($urandom, 2 * i + 1);
      run_and_drain();
      // Receiver holds off for a long while so that the input stalls.
      set_group(32'd2147483647, 32'd1073741789, 7, 32'h1234_5678);
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) add_item($urandom, $urandom);
      run_and_drain();
      // Random part over several groups, the widest ones included.
      calm = 1'b1;
      set_group(23, 11, 4, 7);
      for (int i = 0; i < 15; i++) add_item($urandom, $urandom_range(0, 30));
      run_and_drain();
      calm = 1'b0;
      set_group(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      for (int i = 0; i < 10; i++) add_item($urandom, $urandom);
      run_and_drain();
      set_group($urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < 15; i++) add_item($urandom, $urandom);
      run_and_drain();
      set_group(607, 101, 64, $urandom);
      for (int i = 0; i < 40; i++) add_item($urandom, $urandom);
      run_and_drain();
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
